### rtl/checked_signed_alu_unit_defines.svh
`ifndef CHECKED_SIGNED_ALU_UNIT_DEFINES_SVH
`define CHECKED_SIGNED_ALU_UNIT_DEFINES_SVH

// implication in the same cycle
`define CSA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("checked_signed_alu_unit: assertion failed");

// implication in the next cycle
`define CSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("checked_signed_alu_unit: assertion failed");

`endif

### rtl/csa_pkg.sv
`timescale 1ns / 1ps

package csa_pkg;

  localparam int WIDTH_DEF = 32;

  localparam logic [2:0] ACT_NEG = 3'd0;
  localparam logic [2:0] ACT_ADD = 3'd1;
  localparam logic [2:0] ACT_SUB = 3'd2;
  localparam logic [2:0] ACT_MUL = 3'd3;
  localparam logic [2:0] ACT_DIV = 3'd4;

  localparam logic [2:0] ST_OK  = 3'd0;
  localparam logic [2:0] ST_NEG = 3'd1;
  localparam logic [2:0] ST_ADD = 3'd2;
  localparam logic [2:0] ST_SUB = 3'd3;
  localparam logic [2:0] ST_MUL = 3'd4;
  localparam logic [2:0] ST_DIV = 3'd5;

endpackage

### rtl/csa_mul.sv
`timescale 1ns / 1ps

module csa_mul #(
  parameter int WIDTH = csa_pkg::WIDTH_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] ma,
  input  logic [WIDTH-1:0] mb,
  input  logic             neg,
  output logic [WIDTH-1:0] mul_val,
  output logic             mul_ovf
);
  import csa_pkg::*;

  localparam int H = (WIDTH + 1) / 2;
  localparam int L = WIDTH - H;
  localparam int PW = 2 * WIDTH;
  localparam logic [PW-1:0] SIGN_P = {{WIDTH{1'b0}}, 1'b1, {(WIDTH-1){1'b0}}};

  logic [2*H-1:0]   pp0_r;
  logic [WIDTH-1:0] pp1_r, pp2_r;
  logic [2*L-1:0]   pp3_r;
  logic             neg1_r, neg2_r;
  logic [PW-1:0]    prod_r;
  logic [PW-1:0]    prod_nxt;
  logic [WIDTH-1:0] val_r;
  logic             ovf_r;

  // stage 1: partial products on half-width pieces
  always_ff @(posedge clk) begin
    if (en) begin
      pp0_r  <= ma[H-1:0] * mb[H-1:0];
      pp1_r  <= ma[H-1:0] * mb[WIDTH-1:H];
      pp2_r  <= ma[WIDTH-1:H] * mb[H-1:0];
      pp3_r  <= ma[WIDTH-1:H] * mb[WIDTH-1:H];
      neg1_r <= neg;
    end
  end

  always_comb begin
    prod_nxt = {{(PW-2*H){1'b0}}, pp0_r}
             + ({{WIDTH{1'b0}}, pp1_r} << H)
             + ({{WIDTH{1'b0}}, pp2_r} << H)
             + ({{(PW-2*L){1'b0}}, pp3_r} << (2 * H));
  end

  // stage 2: full magnitude product
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      neg2_r <= neg1_r;
    end
  end

  // stage 3: wrap and range check
  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= neg2_r ? (~prod_r[WIDTH-1:0] + 1'b1) : prod_r[WIDTH-1:0];
      ovf_r <= neg2_r ? (prod_r > SIGN_P) : (prod_r >= SIGN_P);
    end
  end

  assign mul_val = val_r;
  assign mul_ovf = ovf_r;

endmodule

### rtl/csa_div.sv
`timescale 1ns / 1ps

module csa_div #(
  parameter int WIDTH = csa_pkg::WIDTH_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] dvd,
  input  logic [WIDTH-1:0] dvs,
  output logic [WIDTH-1:0] quo
);
  import csa_pkg::*;

  logic [WIDTH-1:0] rem_r [1:WIDTH];
  logic [WIDTH-1:0] quo_r [1:WIDTH];
  logic [WIDTH-1:0] dvs_r [1:WIDTH];

  // one restoring step per stage, one quotient bit each
  for (genvar j = 1; j <= WIDTH; j++) begin : g_stage
    logic [WIDTH-1:0] rem_p, quo_p, dvs_p;
    logic [WIDTH:0]   trial, diff;
    logic             ge;

    if (j == 1) begin : g_first
      assign rem_p = '0;
      assign quo_p = dvd;
      assign dvs_p = dvs;
    end else begin : g_next
      assign rem_p = rem_r[j-1];
      assign quo_p = quo_r[j-1];
      assign dvs_p = dvs_r[j-1];
    end

    assign trial = {rem_p, quo_p[WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_p};
    assign ge    = trial >= {1'b0, dvs_p};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        quo_r[j] <= {quo_p[WIDTH-2:0], ge};
        dvs_r[j] <= dvs_p;
      end
    end
  end

  assign quo = quo_r[WIDTH];

endmodule

### rtl/checked_signed_alu_unit.sv
`timescale 1ns / 1ps
`include "checked_signed_alu_unit_defines.svh"

// channel  | ports                                  | direction
// input    | in_valid in_stall in_action in_lhs in_rhs | in
// result   | out_valid out_stall out_value out_status | out
//
// One word accepted per cycle while in_stall is low; a result passes stage 0, stages
// 1 to WIDTH and the output register, a depth set by the divider, which resolves one quotient bit per stage.
// Reset clears only the valid bits and the skid flag.
// A stalled result parks one following word in a skid register; the pipeline
// freezes only while that skid register is full.

module checked_signed_alu_unit #(
  parameter int WIDTH = csa_pkg::WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_action,
  input  logic signed [WIDTH-1:0] in_lhs,
  input  logic signed [WIDTH-1:0] in_rhs,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [WIDTH-1:0] out_value,
  output logic [2:0]              out_status
);
  import csa_pkg::*;

  localparam logic [WIDTH-1:0] SIGNB = {1'b1, {(WIDTH-1){1'b0}}};

  logic             adv;
  logic [WIDTH-1:0] a, b, neg_w, add_w, sub_w;
  logic [WIDTH-1:0] sval_nxt;
  logic [2:0]       sst_nxt;

  logic             v_r     [0:WIDTH];
  logic [2:0]       act_r   [0:WIDTH];
  logic [WIDTH-1:0] sval_r  [0:WIDTH];
  logic [2:0]       sst_r   [0:WIDTH];
  logic             sgn_r   [0:WIDTH];
  logic             dverr_r [0:WIDTH];
  logic [WIDTH-1:0] ma_r, mb_r;

  logic [WIDTH-1:0] mul_val, quo;
  logic             mul_ovf;
  logic [WIDTH-1:0] mval_r [4:WIDTH];
  logic             movf_r [4:WIDTH];

  logic [WIDTH-1:0] wval;
  logic [2:0]       wst;
  logic             out_v_r, skid_v_r;
  logic [WIDTH-1:0] out_val_r, skid_val_r;
  logic [2:0]       out_st_r, skid_st_r;

  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;

  assign a     = $unsigned(in_lhs);
  assign b     = $unsigned(in_rhs);
  assign neg_w = ~a + 1'b1;
  assign add_w = a + b;
  assign sub_w = a - b;

  always_comb begin
    sval_nxt = '0;
    sst_nxt  = ST_OK;
    case (in_action)
      ACT_NEG: begin
        sval_nxt = neg_w;
        sst_nxt  = (a == SIGNB) ? ST_NEG : ST_OK;
      end
      ACT_ADD: begin
        sval_nxt = add_w;
        sst_nxt  = ((a[WIDTH-1] ^ add_w[WIDTH-1]) & (b[WIDTH-1] ^ add_w[WIDTH-1]))
                   ? ST_ADD : ST_OK;
      end
      ACT_SUB: begin
        sval_nxt = sub_w;
        sst_nxt  = ((a[WIDTH-1] ^ b[WIDTH-1]) & (a[WIDTH-1] ^ sub_w[WIDTH-1]))
                   ? ST_SUB : ST_OK;
      end
      default: begin
        sval_nxt = '0;
        sst_nxt  = ST_OK;
      end
    endcase
  end

  // stage 0: operand prep
  always_ff @(posedge clk) begin
    if (adv) begin
      act_r[0]   <= in_action;
      sval_r[0]  <= sval_nxt;
      sst_r[0]   <= sst_nxt;
      sgn_r[0]   <= a[WIDTH-1] ^ b[WIDTH-1];
      dverr_r[0] <= (b == '0) || ((a == SIGNB) && (b == '1));
      ma_r       <= a[WIDTH-1] ? neg_w : a;
      mb_r       <= b[WIDTH-1] ? (~b + 1'b1) : b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  for (genvar k = 1; k <= WIDTH; k++) begin : g_line
    always_ff @(posedge clk) begin
      if (adv) begin
        act_r[k]   <= act_r[k-1];
        sval_r[k]  <= sval_r[k-1];
        sst_r[k]   <= sst_r[k-1];
        sgn_r[k]   <= sgn_r[k-1];
        dverr_r[k] <= dverr_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  csa_mul #(.WIDTH(WIDTH)) u_mul (
    .clk     (clk),
    .en      (adv),
    .ma      (ma_r),
    .mb      (mb_r),
    .neg     (sgn_r[0]),
    .mul_val (mul_val),
    .mul_ovf (mul_ovf)
  );

  csa_div #(.WIDTH(WIDTH)) u_div (
    .clk (clk),
    .en  (adv),
    .dvd (ma_r),
    .dvs (mb_r),
    .quo (quo)
  );

  for (genvar k = 4; k <= WIDTH; k++) begin : g_mline
    always_ff @(posedge clk) begin
      if (adv) begin
        if (k == 4) begin
          mval_r[k] <= mul_val;
          movf_r[k] <= mul_ovf;
        end else begin
          mval_r[k] <= mval_r[k-1];
          movf_r[k] <= movf_r[k-1];
        end
      end
    end
  end

  always_comb begin
    wval = sval_r[WIDTH];
    wst  = sst_r[WIDTH];
    case (act_r[WIDTH])
      ACT_MUL: begin
        wval = mval_r[WIDTH];
        wst  = movf_r[WIDTH] ? ST_MUL : ST_OK;
      end
      ACT_DIV: begin
        if (dverr_r[WIDTH]) begin
          wval = '0;
          wst  = ST_DIV;
        end else begin
          wval = sgn_r[WIDTH] ? (~quo + 1'b1) : quo;
          wst  = ST_OK;
        end
      end
      default: begin
        wval = sval_r[WIDTH];
        wst  = sst_r[WIDTH];
      end
    endcase
  end

  // output register with one-word skid behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      out_v_r  <= skid_v_r || (adv && v_r[WIDTH]);
      skid_v_r <= 1'b0;
    end else if (adv && v_r[WIDTH]) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || !out_stall) begin
      out_val_r <= skid_v_r ? skid_val_r : wval;
      out_st_r  <= skid_v_r ? skid_st_r : wst;
    end else if (adv && v_r[WIDTH]) begin
      skid_val_r <= wval;
      skid_st_r  <= wst;
    end
  end

  assign out_valid  = out_v_r;
  assign out_value  = $signed(out_val_r);
  assign out_status = out_st_r;

  `CSA_ASSERT_IMPL(a_skid_behind_out, skid_v_r, out_v_r)
  `CSA_ASSERT_NEXT(a_stall_keeps_word, out_v_r && out_stall, out_v_r && $stable(out_val_r))
  `CSA_ASSERT_IMPL(a_div_err_zero, out_v_r && (out_st_r == ST_DIV), out_val_r == '0)
  `CSA_ASSERT_IMPL(a_neg_ovf_min, out_v_r && (out_st_r == ST_NEG), out_val_r == SIGNB)

endmodule

### tb/sv/checked_signed_alu_unit_tb.sv
`timescale 1ns / 1ps

module checked_signed_alu_unit_tb;
  import csa_pkg::*;

  localparam int W = 32;
  localparam int LAT = W + 2;
  localparam int N_RAND = 1300;
  localparam int N_DIR = 22;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG1 = '1;

  typedef struct packed {
    logic [W-1:0] value;
    logic [2:0]   status;
  } alu_res_t;

  typedef struct {
    logic [2:0]   act;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         known;
    logic [W-1:0] value;
    logic [2:0]   status;
  } vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_action = '0;
  logic signed [W-1:0] in_lhs = '0;
  logic signed [W-1:0] in_rhs = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [W-1:0] out_value;
  logic [2:0] out_status;

  alu_res_t pending_q[$];
  int mismatches = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  checked_signed_alu_unit #(.WIDTH(W)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_lhs(in_lhs), .in_rhs(in_rhs),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .out_status(out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [W-1:0] mag(logic [W-1:0] v);
    return v[W-1] ? -v : v;
  endfunction

  function automatic alu_res_t alu_predict(logic [2:0] act, logic [W-1:0] a,
                                           logic [W-1:0] b);
    alu_res_t r;
    logic signed [2*W-1:0] prod;
    logic [W-1:0] q;
    r = '0;
    case (act)
      ACT_NEG: begin
        r.value = -a;
        if (a == MINV) r.status = ST_NEG;
      end
      ACT_ADD: begin
        r.value = a + b;
        if ((a[W-1] == b[W-1]) && (r.value[W-1] != a[W-1])) r.status = ST_ADD;
      end
      ACT_SUB: begin
        r.value = a - b;
        if ((a[W-1] != b[W-1]) && (r.value[W-1] != a[W-1])) r.status = ST_SUB;
      end
      ACT_MUL: begin
        prod = $signed(a) * $signed(b);
        r.value = prod[W-1:0];
        if (prod != {{W{prod[W-1]}}, prod[W-1:0]}) r.status = ST_MUL;
      end
      ACT_DIV: begin
        if (b == '0 || (a == MINV && b == NEG1)) begin
          r.status = ST_DIV;
        end else begin
          q = mag(a) / mag(b);
          r.value = (a[W-1] ^ b[W-1]) ? -q : q;
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // input and result side: sample at rising edge; random stall bursts below
  always @(posedge clk) begin
    alu_res_t exp_r;
    cycles <= cycles + 1;
    if (rst_n && in_valid && !in_stall)
      pending_q.push_back(alu_predict(in_action, in_lhs, in_rhs));
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: value %h status %0d",
                                       out_value, out_status);
      end else begin
        exp_r = pending_q.pop_front();
        if (out_value !== exp_r.value || out_status !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp value %h status %0d, got value %h status %0d",
                     exp_r.value, exp_r.status, out_value, out_status);
        end
      end
    end
  end

  initial begin
    int burst;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (quiet || !rst_n) begin
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        if (burst == 0) out_stall <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 8);
        out_stall <= 1'b1;
      end
    end
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // drive one word, holding it until taken; random gaps before it unless quiet
  task automatic send_word(logic [2:0] act, logic [W-1:0] a, logic [W-1:0] b);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_lhs <= a;
    in_rhs <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [W-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return MINV;
      1: return MAXV;
      2: return W'($signed($urandom_range(0, 8)) - 4);
      3: return W'($signed($urandom_range(0, 2000)) - 1000);
      4: return W'({$urandom, $urandom} >> $urandom_range(0, W - 1));
      default: return W'({$urandom, $urandom});
    endcase
  endfunction

  vec_t dir_tbl [N_DIR] = '{
    '{ACT_NEG, MINV, '0,   1'b1, MINV, ST_NEG},
    '{ACT_NEG, MAXV, '0,   1'b1, MINV + 1, ST_OK},
    '{ACT_NEG, '0,   NEG1, 1'b1, '0, ST_OK},
    '{ACT_ADD, MAXV, 1,    1'b1, MINV, ST_ADD},
    '{ACT_ADD, MINV, NEG1, 1'b1, MAXV, ST_ADD},
    '{ACT_ADD, MAXV, MINV, 1'b1, NEG1, ST_OK},
    '{ACT_SUB, MINV, 1,    1'b1, MAXV, ST_SUB},
    '{ACT_SUB, MAXV, NEG1, 1'b1, MINV, ST_SUB},
    '{ACT_SUB, NEG1, MINV, 1'b1, MAXV, ST_OK},
    '{ACT_MUL, MINV, NEG1, 1'b1, MINV, ST_MUL},
    '{ACT_MUL, MAXV, MAXV, 1'b0, '0, ST_OK},
    '{ACT_MUL, MINV, 1,    1'b1, MINV, ST_OK},
    '{ACT_MUL, 32'h0001_0000, 32'hffff_8000, 1'b1, MINV, ST_OK},
    '{ACT_MUL, 32'h0001_0000, 32'h0000_8000, 1'b1, MINV, ST_MUL},
    '{ACT_DIV, 7,    '0,   1'b1, '0, ST_DIV},
    '{ACT_DIV, MINV, NEG1, 1'b1, '0, ST_DIV},
    '{ACT_DIV, NEG1 - 6, 2, 1'b1, NEG1 - 2, ST_OK},
    '{ACT_DIV, MINV, MINV, 1'b1, 1, ST_OK},
    '{ACT_DIV, MAXV, MINV, 1'b1, '0, ST_OK},
    '{3'd5, MAXV, MAXV,    1'b1, '0, ST_OK},
    '{3'd6, MINV, NEG1,    1'b1, '0, ST_OK},
    '{3'd7, NEG1, NEG1,    1'b1, '0, ST_OK}
  };

  initial begin
    alu_res_t r;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].known) begin
        r = alu_predict(dir_tbl[i].act, dir_tbl[i].a, dir_tbl[i].b);
        if (r.value !== dir_tbl[i].value || r.status !== dir_tbl[i].status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row %0d: exp value %h status %0d, got value %h status %0d",
                     i, dir_tbl[i].value, dir_tbl[i].status, r.value, r.status);
        end
      end
      send_word(dir_tbl[i].act, dir_tbl[i].a, dir_tbl[i].b);
    end
    in_valid <= 1'b0;
    // drain fully once before random traffic
    while (pending_q.size() != 0) @(negedge clk);
    for (int n = 0; n < N_RAND; n++) begin
      if (n == N_RAND - 200) quiet = 1'b1;
      send_word(($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4)),
                rand_operand(), rand_operand());
    end
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (LAT + 4) @(negedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
